@@ rtl/bop_pkg.sv @@
package bop_pkg;

	localparam int unsigned PRICE_W = 32;
	localparam int unsigned STEPS_W = 9;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_UP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS   = 3'd4;

	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	typedef struct packed {
		logic [PRICE_W-1:0] asset_price;
		logic [PRICE_W-1:0] strike_price;
		logic               american;
	} in_t;

	typedef struct packed {
		logic [PRICE_W-1:0] option_value;
		logic               saturated;
	} out_t;

	// datapath operations issued by the sequencer, one per cycle
	typedef enum logic [4:0] {
		DP_IDLE,
		DP_LOAD,     // capture request, A[0] = spot, clear saturation flag
		DP_F_RD,     // read A[addr]
		DP_F_MUL_U,  // prod = a_rd * u
		DP_F_MUL_D,  // prod = a_rd * d
		DP_F_WR,     // A[addr] = scale(prod)
		DP_P_RD,     // read A[addr]
		DP_P_WR,     // V[addr] = payoff(a_rd)
		DP_B_RD1,    // read A[addr], V[addr] (upper child)
		DP_B_RD2,    // read V[addr] (lower child); prod = p * Vup
		DP_B_M1,     // mix = prod; prod = q * Vdown
		DP_B_M2,     // c = round31(mix + prod)
		DP_B_M3,     // prod = c * disc
		DP_B_M4,     // v = round31(prod); prod = Aup * d
		DP_B_WR,     // write node value (and node asset when American)
		DP_R_RD,     // read V[0]
		DP_OUT       // load result register
	} dp_op_t;

	// (s * f + 2^29) >> 30 with saturation; bit 32 flags saturation
	function automatic logic [32:0] scale_price(input logic [63:0] prod);
		logic [64:0] r;
		r = {1'b0, prod} + 65'(ONE_Q30 >> 1);
		if (r[64:62] != 3'd0) begin
			scale_price = {1'b1, 32'hFFFF_FFFF};
		end else begin
			scale_price = {1'b0, r[61:30]};
		end
	endfunction

	function automatic logic [31:0] call_payoff(input logic [31:0] s, input logic [31:0] k);
		call_payoff = (s > k) ? (s - k) : 32'd0;
	endfunction

endpackage

@@ rtl/bop_ctrl.sv @@
module bop_ctrl #(
	parameter int unsigned MAX_STEPS = 256,
	parameter int unsigned AW = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic [bop_pkg::STEPS_W-1:0]   num_steps,
	output bop_pkg::dp_op_t               op,
	output logic [AW-1:0]                 addr
);

	typedef enum logic [3:0] {
		S_IDLE, S_F_RD, S_F_MUL, S_F_WR, S_P_RD, S_P_WR,
		S_B_RD1, S_B_RD2, S_B_M1, S_B_M2, S_B_M3, S_B_M4, S_B_WR,
		S_R_RD, S_R_OUT
	} state_t;

	state_t      state_q;
	logic [AW-1:0] n_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] nmax;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		if (32'(num_steps) > 32'(MAX_STEPS)) begin
			nmax = AW'(MAX_STEPS);
		end else begin
			nmax = AW'(num_steps);
		end
	end

	always_comb begin
		op   = bop_pkg::DP_IDLE;
		addr = j_q;
		unique case (state_q)
			S_IDLE: begin
				addr = '0;
				if (in_valid) op = bop_pkg::DP_LOAD;
			end
			S_F_RD: begin
				op   = bop_pkg::DP_F_RD;
				addr = (j_q == '0) ? '0 : j_q - AW'(1);
			end
			S_F_MUL: op = (j_q == '0) ? bop_pkg::DP_F_MUL_D : bop_pkg::DP_F_MUL_U;
			S_F_WR:  op = bop_pkg::DP_F_WR;
			S_P_RD:  op = bop_pkg::DP_P_RD;
			S_P_WR:  op = bop_pkg::DP_P_WR;
			S_B_RD1: begin
				op   = bop_pkg::DP_B_RD1;
				addr = j_q + AW'(1);
			end
			S_B_RD2: op = bop_pkg::DP_B_RD2;
			S_B_M1:  op = bop_pkg::DP_B_M1;
			S_B_M2:  op = bop_pkg::DP_B_M2;
			S_B_M3:  op = bop_pkg::DP_B_M3;
			S_B_M4:  op = bop_pkg::DP_B_M4;
			S_B_WR:  op = bop_pkg::DP_B_WR;
			S_R_RD: begin
				op   = bop_pkg::DP_R_RD;
				addr = '0;
			end
			S_R_OUT: begin
				addr = '0;
				if (out_free) op = bop_pkg::DP_OUT;
			end
			default: op = bop_pkg::DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_R_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (nmax == '0) begin
							j_q     <= '0;
							state_q <= S_P_RD;
						end else begin
							n_q     <= AW'(1);
							j_q     <= AW'(1);
							state_q <= S_F_RD;
						end
					end
				end
				S_F_RD:  state_q <= S_F_MUL;
				S_F_MUL: state_q <= S_F_WR;
				S_F_WR: begin
					if (j_q != '0) begin
						j_q     <= j_q - AW'(1);
						state_q <= S_F_RD;
					end else if (n_q != nmax) begin
						n_q     <= n_q + AW'(1);
						j_q     <= n_q + AW'(1);
						state_q <= S_F_RD;
					end else begin
						j_q     <= '0;
						state_q <= S_P_RD;
					end
				end
				S_P_RD: state_q <= S_P_WR;
				S_P_WR: begin
					if (j_q != nmax) begin
						j_q     <= j_q + AW'(1);
						state_q <= S_P_RD;
					end else if (nmax == '0) begin
						state_q <= S_R_RD;
					end else begin
						n_q     <= nmax;
						j_q     <= '0;
						state_q <= S_B_RD1;
					end
				end
				S_B_RD1: state_q <= S_B_RD2;
				S_B_RD2: state_q <= S_B_M1;
				S_B_M1:  state_q <= S_B_M2;
				S_B_M2:  state_q <= S_B_M3;
				S_B_M3:  state_q <= S_B_M4;
				S_B_M4:  state_q <= S_B_WR;
				S_B_WR: begin
					if (j_q != n_q - AW'(1)) begin
						j_q     <= j_q + AW'(1);
						state_q <= S_B_RD1;
					end else if (n_q != AW'(1)) begin
						n_q     <= n_q - AW'(1);
						j_q     <= '0;
						state_q <= S_B_RD1;
					end else begin
						state_q <= S_R_RD;
					end
				end
				S_R_RD: state_q <= S_R_OUT;
				S_R_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/bop_datapath.sv @@
module bop_datapath #(
	parameter int unsigned MAX_STEPS = 256,
	parameter int unsigned AW = 9
) (
	input  logic             clk,
	input  bop_pkg::dp_op_t  op,
	input  logic [AW-1:0]    addr,
	input  bop_pkg::in_t     in_data,
	input  logic [31:0]      up_factor,
	input  logic [31:0]      down_factor,
	input  logic [31:0]      prob_p,
	input  logic [31:0]      prob_q,
	input  logic [31:0]      disc,
	output bop_pkg::out_t    out_data
);

	localparam int unsigned DEPTH = MAX_STEPS + 1;

	logic [31:0] a_mem [DEPTH];
	logic [31:0] v_mem [DEPTH];

	logic [31:0] a_rd_q, v_rd_q;
	logic [31:0] strike_q;
	logic        amer_q;
	logic        sat_q;
	logic [63:0] prod_q;
	logic [63:0] mix_q;
	logic [31:0] c_q;
	logic [31:0] v_q;
	bop_pkg::out_t out_q;

	logic        a_we, v_we, a_re, v_re;
	logic [31:0] a_wd, v_wd;
	logic [31:0] mul_a, mul_b;
	logic        mul_en;
	logic [32:0] scaled;
	logic [31:0] ex_val;
	logic [65:0] mix_sum;
	logic [64:0] disc_r;

	assign scaled  = bop_pkg::scale_price(prod_q);
	assign ex_val  = bop_pkg::call_payoff(scaled[31:0], strike_q);
	assign mix_sum = {2'b00, mix_q} + {2'b00, prod_q} + 66'(bop_pkg::ONE_Q30);
	assign disc_r  = {1'b0, prod_q} + 65'(bop_pkg::ONE_Q30);

	always_comb begin
		a_we   = 1'b0;
		v_we   = 1'b0;
		a_re   = 1'b0;
		v_re   = 1'b0;
		a_wd   = scaled[31:0];
		v_wd   = v_q;
		mul_en = 1'b0;
		mul_a  = a_rd_q;
		mul_b  = up_factor;
		unique case (op)
			bop_pkg::DP_LOAD: begin
				a_we = 1'b1;
				a_wd = in_data.asset_price;
			end
			bop_pkg::DP_F_RD, bop_pkg::DP_P_RD: a_re = 1'b1;
			bop_pkg::DP_F_MUL_U: mul_en = 1'b1;
			bop_pkg::DP_F_MUL_D: begin
				mul_en = 1'b1;
				mul_b  = down_factor;
			end
			bop_pkg::DP_F_WR: a_we = 1'b1;
			bop_pkg::DP_P_WR: begin
				v_we = 1'b1;
				v_wd = bop_pkg::call_payoff(a_rd_q, strike_q);
			end
			bop_pkg::DP_B_RD1: begin
				a_re = 1'b1;
				v_re = 1'b1;
			end
			bop_pkg::DP_B_RD2: begin
				v_re   = 1'b1;
				mul_en = 1'b1;
				mul_a  = v_rd_q;
				mul_b  = prob_p;
			end
			bop_pkg::DP_B_M1: begin
				mul_en = 1'b1;
				mul_a  = v_rd_q;
				mul_b  = prob_q;
			end
			bop_pkg::DP_B_M3: begin
				mul_en = 1'b1;
				mul_a  = c_q;
				mul_b  = disc;
			end
			bop_pkg::DP_B_M4: begin
				mul_en = amer_q;
				mul_b  = down_factor;
			end
			bop_pkg::DP_B_WR: begin
				a_we = amer_q;
				v_we = 1'b1;
				v_wd = (amer_q && ex_val > v_q) ? ex_val : v_q;
			end
			bop_pkg::DP_R_RD: v_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) a_mem[addr] <= a_wd;
		if (a_re) a_rd_q <= a_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (v_we) v_mem[addr] <= v_wd;
		if (v_re) v_rd_q <= v_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
		unique case (op)
			bop_pkg::DP_LOAD: begin
				strike_q <= in_data.strike_price;
				amer_q   <= in_data.american;
				sat_q    <= 1'b0;
			end
			bop_pkg::DP_F_WR: sat_q <= sat_q | scaled[32];
			bop_pkg::DP_B_M1: mix_q <= prod_q;
			bop_pkg::DP_B_M2: c_q <= mix_sum[62:31];
			bop_pkg::DP_B_M4: v_q <= disc_r[62:31];
			bop_pkg::DP_B_WR: sat_q <= sat_q | (amer_q & scaled[32]);
			bop_pkg::DP_OUT: begin
				out_q.option_value <= v_rd_q;
				out_q.saturated    <= sat_q;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

@@ rtl/binomial_option_pricer.sv @@
// Binomial lattice call option pricer, UQ16.16 prices.
//
// Channels: in_valid/in_ready/in_data carry one pricing request (spot,
// strike, American flag); out_valid/out_ready/out_data return the root option
// value and a saturation flag. cfg_valid/cfg_ready/cfg_index/cfg_data write
// the lattice registers (0 up factor, 1 down factor, 2 up probability,
// 3 discount, 4 step count); cfg_ready is always high. Users must write only while idle;
// the block does not enforce it.
// For N steps: the forward price build reads, multiplies and writes each of
// N(N+3)/2 nodes; payoff reads and writes each terminal node; backward
// induction reads, mixes, discounts and writes each of N(N+1)/2 nodes;
// plus setup and readout. One 32x32 multiplier and one read port per node
// memory serve all of this. One request is in flight at a time.
//
// Reset clears the controller and restores register defaults; node memories
// hold garbage until a request writes them. A stalled result sits in the
// output register; a new request is accepted meanwhile and runs until its
// own result is ready, then waits for the register to free.
module binomial_option_pricer #(
	parameter int unsigned MAX_STEPS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bop_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bop_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bop_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int unsigned AW = $clog2(MAX_STEPS + 1);

	logic [31:0] up_q, down_q, prob_q, disc_q;
	logic [bop_pkg::STEPS_W-1:0] steps_q;
	logic [31:0] p_eff, q_eff, disc_eff;
	bop_pkg::dp_op_t op;
	logic [AW-1:0] addr;

	assign cfg_ready = 1'b1;

	// register file; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= bop_pkg::ONE_Q30;
			down_q  <= bop_pkg::ONE_Q30;
			prob_q  <= bop_pkg::ONE_Q30;
			disc_q  <= bop_pkg::ONE_Q31;
			steps_q <= bop_pkg::STEPS_W'(1);
		end else if (cfg_valid) begin
			priority case (cfg_index)
				bop_pkg::REG_UP_FACTOR:   up_q    <= cfg_data;
				bop_pkg::REG_DOWN_FACTOR: down_q  <= cfg_data;
				bop_pkg::REG_PROB_UP:     prob_q  <= cfg_data;
				bop_pkg::REG_DISCOUNT:    disc_q  <= cfg_data;
				bop_pkg::REG_NUM_STEPS:   steps_q <= cfg_data[bop_pkg::STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// probabilities and discount above one clamp to one
	assign p_eff    = (prob_q > bop_pkg::ONE_Q31) ? bop_pkg::ONE_Q31 : prob_q;
	assign q_eff    = bop_pkg::ONE_Q31 - p_eff;
	assign disc_eff = (disc_q > bop_pkg::ONE_Q31) ? bop_pkg::ONE_Q31 : disc_q;

	bop_ctrl #(
		.MAX_STEPS(MAX_STEPS),
		.AW(AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.num_steps (steps_q),
		.op        (op),
		.addr      (addr)
	);

	bop_datapath #(
		.MAX_STEPS(MAX_STEPS),
		.AW(AW)
	) u_datapath (
		.clk         (clk),
		.op          (op),
		.addr        (addr),
		.in_data     (in_data),
		.up_factor   (up_q),
		.down_factor (down_q),
		.prob_p      (p_eff),
		.prob_q      (q_eff),
		.disc        (disc_eff),
		.out_data    (out_data)
	);

endmodule
